// File: sv/lin_master_frame_sender_macros.svh
// Assertion macros shared by the LIN frame sender RTL.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef LIN_MASTER_FRAME_SENDER_MACROS_SVH
`define LIN_MASTER_FRAME_SENDER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LMFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LMFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lmfs_pkg.sv
// Shared types, codes and helpers for the LIN master frame sender.
// No dependencies; imported by every lmfs module and the top level.
package lmfs_pkg;

  localparam int MAX_DATA_BYTES = 8;
  localparam int PH_W  = $clog2(MAX_DATA_BYTES + 3);
  localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  // operation codes
  localparam logic [2:0] OP_SEND  = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_HBEAT = 3'd2;
  localparam logic [2:0] OP_SLEEP = 3'd3;
  localparam logic [2:0] OP_WAKE  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ASLEEP = 2'd1;
  localparam logic [1:0] ST_BAD_ID = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_IS_MASTER  = 2'd0;
  localparam logic [1:0] CFG_HB_ID      = 2'd1;
  localparam logic [1:0] CFG_HB_PERIOD  = 2'd2;
  localparam logic [1:0] CFG_HB_TIMEOUT = 2'd3;

  localparam logic [15:0] HB_PERIOD_RST  = 16'd500;
  localparam logic [15:0] HB_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  SYNC_BYTE      = 8'h55;
  localparam logic [7:0]  ID_MAX         = 8'd63;
  localparam logic [3:0]  HB_LEN         = 4'd2;
  localparam logic [3:0]  LEN_MAX        = 4'(MAX_DATA_BYTES);

  // one queued transaction: a frame to serialize or a status-only result
  typedef struct packed {
    logic        is_frame;
    logic [1:0]  status;
    logic [7:0]  pid;
    logic [3:0]  len;
    logic [63:0] data;
    logic        timeout;
    logic [31:0] sent;
  } lmfs_job_t;

  // LIN 2.1 protected identifier
  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

// File: sv/lmfs_front.sv
// Front end: configuration registers, mode/heartbeat bookkeeping and command decode.
// Depends on lmfs_pkg; feeds lmfs_queue with one job per accepted transaction.
module lmfs_front
  import lmfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        q_full,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_timestamp_ms,
  input  logic [7:0]  in_frame_id,
  input  logic [3:0]  in_data_length,
  input  logic [63:0] in_frame_data,
  output logic        push,
  output lmfs_job_t   push_job
);

  logic        is_master_r;
  logic [5:0]  hb_id_r;
  logic [15:0] hb_period_r;
  logic [15:0] hb_timeout_r;

  logic        bus_active_r,  bus_active_nxt;
  logic [15:0] beat_cnt_r,    beat_cnt_nxt;
  logic [31:0] last_beat_r,   last_beat_nxt;
  logic        timed_out_r,   timed_out_nxt;
  logic [31:0] frame_cnt_r,   frame_cnt_nxt;

  logic [31:0] since_beat;
  logic [3:0]  len_sat;

  assign push       = in_valid && !q_full;
  assign since_beat = in_timestamp_ms - last_beat_r;
  assign len_sat    = (in_data_length > LEN_MAX) ? LEN_MAX : in_data_length;

  always_comb begin
    bus_active_nxt = bus_active_r;
    beat_cnt_nxt   = beat_cnt_r;
    last_beat_nxt  = last_beat_r;
    timed_out_nxt  = timed_out_r;
    frame_cnt_nxt  = frame_cnt_r;
    push_job.is_frame = 1'b0;
    push_job.status   = ST_OK;
    push_job.pid      = make_pid(hb_id_r);
    push_job.len      = HB_LEN;
    push_job.data     = {48'd0, beat_cnt_r};
    case (in_op)
      OP_SEND: begin
        if (!bus_active_r) begin
          push_job.status = ST_ASLEEP;
        end else if (in_frame_id > ID_MAX) begin
          push_job.status = ST_BAD_ID;
        end else begin
          push_job.is_frame = 1'b1;
          push_job.pid      = make_pid(in_frame_id[5:0]);
          push_job.len      = len_sat;
          push_job.data     = in_frame_data;
          frame_cnt_nxt     = frame_cnt_r + 32'd1;
        end
      end
      OP_TICK: begin
        if (!bus_active_r) begin
          push_job.status = ST_ASLEEP;
        end else if (!is_master_r) begin
          if (last_beat_r != 32'd0 && since_beat > {16'd0, hb_timeout_r}) begin
            timed_out_nxt = 1'b1;
          end
        end else if (since_beat >= {16'd0, hb_period_r}) begin
          push_job.is_frame = 1'b1;
          beat_cnt_nxt      = beat_cnt_r + 16'd1;
          last_beat_nxt     = in_timestamp_ms;
          timed_out_nxt     = 1'b0;
          frame_cnt_nxt     = frame_cnt_r + 32'd1;
        end
      end
      OP_HBEAT: begin
        if (!bus_active_r) begin
          push_job.status = ST_ASLEEP;
        end else begin
          push_job.is_frame = 1'b1;
          beat_cnt_nxt      = beat_cnt_r + 16'd1;
          last_beat_nxt     = in_timestamp_ms;
          timed_out_nxt     = 1'b0;
          frame_cnt_nxt     = frame_cnt_r + 32'd1;
        end
      end
      OP_SLEEP: begin
        bus_active_nxt = 1'b0;
      end
      OP_WAKE: begin
        if (!bus_active_r) begin
          bus_active_nxt = 1'b1;
          timed_out_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
    push_job.timeout = timed_out_nxt;
    push_job.sent    = frame_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_master_r  <= 1'b1;
      hb_id_r      <= 6'd0;
      hb_period_r  <= HB_PERIOD_RST;
      hb_timeout_r <= HB_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IS_MASTER:  is_master_r  <= cfg_wdata[0];
        CFG_HB_ID:      hb_id_r      <= cfg_wdata[5:0];
        CFG_HB_PERIOD:  hb_period_r  <= cfg_wdata;
        CFG_HB_TIMEOUT: hb_timeout_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_active_r <= 1'b1;
      beat_cnt_r   <= 16'd0;
      last_beat_r  <= 32'd0;
      timed_out_r  <= 1'b0;
      frame_cnt_r  <= 32'd0;
    end else if (push) begin
      bus_active_r <= bus_active_nxt;
      beat_cnt_r   <= beat_cnt_nxt;
      last_beat_r  <= last_beat_nxt;
      timed_out_r  <= timed_out_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
    end
  end

endmodule

// File: sv/lmfs_queue.sv
// Two-entry job queue between the decode front end and the byte serializer.
// Depends on lmfs_pkg and the shared assertion macros.
`include "lin_master_frame_sender_macros.svh"
module lmfs_queue
  import lmfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lmfs_job_t push_job,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output lmfs_job_t head
);

  lmfs_job_t  mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `LMFS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= 2'd2, "queue count out of range")
  `LMFS_ASSERT_IMP(a_no_overflow, push, !full, "push into full queue")
  `LMFS_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from empty queue")
  `LMFS_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after push")

endmodule

// File: sv/lmfs_back.sv
// Back end: one bus byte or status per unstalled cycle into the output register.
// Depends on lmfs_pkg and the shared assertion macros.
`include "lin_master_frame_sender_macros.svh"
module lmfs_back
  import lmfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  lmfs_job_t   job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_is_last,
  output logic [1:0]  out_status,
  output logic        out_timeout_flag,
  output logic [31:0] out_sent_frames
);

  logic [PH_W-1:0] phase_r, phase_nxt;
  logic [7:0]      sum_r,   sum_nxt;

  logic            out_valid_r;
  logic [7:0]      byte_r;
  logic            byte_valid_r;
  logic            last_r;
  logic [1:0]      status_r;
  logic            timeout_r;
  logic [31:0]     sent_r;

  logic            load_ok;
  logic            fire;
  logic [4:0]      ck_phase;
  logic [PH_W-1:0] data_off;
  logic [IDX_W-1:0] idx;
  logic [7:0]      dbyte;
  logic [8:0]      add;
  logic [7:0]      byte_nxt;
  logic            last_nxt;

  assign load_ok  = !out_valid_r || !out_stall;
  assign fire     = load_ok && !q_empty;
  assign ck_phase = {1'b0, job.len} + 5'd2;
  assign data_off = phase_r - PH_W'(2);
  assign idx      = data_off[IDX_W-1:0];
  assign dbyte    = job.data[{idx, 3'b000} +: 8];
  assign add      = {1'b0, sum_r} + {1'b0, dbyte};

  always_comb begin
    byte_nxt = 8'd0;
    last_nxt = 1'b1;
    sum_nxt  = sum_r;
    if (job.is_frame) begin
      last_nxt = 1'b0;
      if (phase_r == PH_W'(0)) begin
        byte_nxt = SYNC_BYTE;
      end else if (phase_r == PH_W'(1)) begin
        byte_nxt = job.pid;
        sum_nxt  = job.pid;
      end else if (5'(phase_r) == ck_phase) begin
        byte_nxt = ~sum_r;
        last_nxt = 1'b1;
      end else begin
        byte_nxt = dbyte;
        // end-around carry
        sum_nxt  = add[8] ? (add[7:0] + 8'd1) : add[7:0];
      end
    end
    phase_nxt = last_nxt ? PH_W'(0) : (phase_r + PH_W'(1));
  end

  assign pop = fire && last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
      end
      if (load_ok) begin
        out_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sum_r        <= sum_nxt;
      byte_r       <= byte_nxt;
      byte_valid_r <= job.is_frame;
      last_r       <= last_nxt;
      status_r     <= job.status;
      timeout_r    <= job.timeout;
      sent_r       <= job.sent;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = byte_r;
  assign out_byte_valid   = byte_valid_r;
  assign out_is_last      = last_r;
  assign out_status       = status_r;
  assign out_timeout_flag = timeout_r;
  assign out_sent_frames  = sent_r;

  `LMFS_ASSERT_IMP(a_status_last, out_valid_r && !byte_valid_r, last_r,
                   "status-only result not marked last")
  `LMFS_ASSERT_IMP(a_err_no_byte, out_valid_r && status_r != ST_OK, !byte_valid_r,
                   "error status carries a bus byte")
  `LMFS_ASSERT_IMP(a_status_phase, fire && !job.is_frame, phase_r == PH_W'(0),
                   "status job started mid-frame")
  `LMFS_ASSERT_IMP(a_phase_bound, !q_empty && job.is_frame, 5'(phase_r) <= ck_phase,
                   "frame phase beyond checksum")

endmodule

// File: sv/lin_master_frame_sender.sv
// Top level of the LIN master frame sender.
// Depends on lmfs_pkg, lmfs_front, lmfs_queue and lmfs_back.
//
// Usage:
// - Input channel (in_valid/in_stall): one transaction per command: send
//   frame, schedule tick, send heartbeat, sleep or wake.
// - Output channel (out_valid/out_stall): a sent frame yields one transaction
//   per bus byte (sync 0x55, PID, 0..8 data bytes, checksum), the last one
//   flagged by out_is_last; any other outcome yields one status-only
//   transaction with out_byte_valid low.
// - cfg_we/cfg_index/cfg_wdata write the four configuration registers.
// Path: an accepted command is written into the job queue, then loaded into
// the output register. Throughput: the serializer emits one transaction per
// cycle while out_stall is low, so a frame of N data bytes holds the back end
// for N+3 transactions (3 to 11), a status-only command for one. Commands are
// decoded at acceptance into a two-entry queue, so input is taken every cycle
// until that queue fills; the byte serializer sets the sustained rate.
// Reset (rst_n low, synchronous): queue and output empty, bus active,
// counters and timeout flag cleared, registers to their defaults.
// When out_stall is high the output transaction holds, the serializer
// waits, and once the queue is full in_stall rises.
module lin_master_frame_sender
  import lmfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_timestamp_ms,
  input  logic [7:0]  in_frame_id,
  input  logic [3:0]  in_data_length,
  input  logic [63:0] in_frame_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_is_last,
  output logic [1:0]  out_status,
  output logic        out_timeout_flag,
  output logic [31:0] out_sent_frames
);

  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;
  lmfs_job_t push_job;
  lmfs_job_t head_job;

  // input is stalled only by a full job queue
  assign in_stall = q_full;

  lmfs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .q_full          (q_full),
    .in_op           (in_op),
    .in_timestamp_ms (in_timestamp_ms),
    .in_frame_id     (in_frame_id),
    .in_data_length  (in_data_length),
    .in_frame_data   (in_frame_data),
    .push            (push),
    .push_job        (push_job)
  );

  lmfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head_job)
  );

  // serializer: one bus byte or status result per cycle while out_stall is low
  lmfs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .job              (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_is_last      (out_is_last),
    .out_status       (out_status),
    .out_timeout_flag (out_timeout_flag),
    .out_sent_frames  (out_sent_frames)
  );

endmodule
